// ----- src/wdsc_pkg.sv -----
// Package for the warp divergence stack control block.
// Holds lane count, operation and status codes, payload and command structs.
// No dependencies.
package wdsc_pkg;

  localparam int unsigned LANES = 4;
  localparam int unsigned STACK_DEPTH_DEF = 8;
  localparam logic [3:0] LIMIT_RESET = 4'd8;
  localparam logic [31:0] PC_STEP = 32'd4;

  typedef enum logic [1:0] {
    OP_TMC   = 2'd0,
    OP_SPLIT = 2'd1,
    OP_JOIN  = 2'd2,
    OP_PRED  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]       operation;
    logic [31:0]      pc;
    logic [LANES-1:0] lane_cond;
    logic             cond_negate;
    logic             tokenless;
    logic [31:0]      scalar_rs1;
    logic [LANES-1:0] restore_mask;
    logic             end_of_packet;
    logic             release_default;
  } wdsc_in_t;

  typedef struct packed {
    logic [LANES-1:0] next_mask;
    logic             warp_resume;
    logic [3:0]       dst_value;
    logic             redirect;
    logic [31:0]      redirect_pc;
    logic             divergence;
    logic [1:0]       status;
  } wdsc_out_t;

  typedef struct packed {
    logic capture;
    logic execute;
    logic cfg_write;
  } wdsc_cmd_t;

endpackage

// ----- src/wdsc_ctrl.sv -----
// Controller state machine: accepts an item, runs the execute state, then strobes the result.
// Depends on wdsc_pkg.
module wdsc_ctrl import wdsc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  output logic      result_valid_o,
  output wdsc_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) state_d = S_EXEC;
      end
      S_EXEC: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    done_d = (state_q == S_EXEC);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy           = (state_q == S_EXEC);
  assign cfg_ready_o    = (state_q == S_IDLE);
  assign result_valid_o = done_q;
  assign cmd_o.capture   = start && (state_q == S_IDLE);
  assign cmd_o.execute   = (state_q == S_EXEC);
  assign cmd_o.cfg_write = cfg_valid_i && (state_q == S_IDLE);

  a_accept_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> cmd_o.execute)
    else $error("accepted item did not enter execute");
  a_exec_then_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.execute |=> result_valid_o && !cmd_o.execute)
    else $error("execute not followed by a single result strobe");
  a_no_cfg_while_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.cfg_write && cmd_o.execute))
    else $error("config write during execute");

endmodule

// ----- src/wdsc_dp.sv -----
// Datapath: thread mask, stack count, config register, reconvergence stack memory
// and result register. Depends on wdsc_pkg.
module wdsc_dp import wdsc_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  wdsc_cmd_t  cmd_i,
  input  logic [3:0] cfg_data_i,
  input  wdsc_in_t   in_i,
  output wdsc_out_t  result_o
);

  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned LimW  = (CntW > 4) ? CntW : 4;

  typedef struct packed {
    logic [LANES-1:0] mask;
    logic [31:0]      else_pc;
    logic             fallthrough;
  } entry_t;

  entry_t           mem_q [STACK_DEPTH];
  entry_t           top_q;
  wdsc_in_t         item_q;
  wdsc_out_t        res_q, res_d;
  logic [LANES-1:0] mask_q, mask_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [3:0]       limit_q;

  logic             we;
  logic [AddrW-1:0] waddr;
  entry_t           wdata;

  logic [LANES-1:0] cond, taken, other, deferred, pred;
  logic [LimW-1:0]  limit_w;
  logic             full, act, set_mask;

  always_comb begin
    cond     = item_q.lane_cond ^ {LANES{item_q.cond_negate}};
    taken    = mask_q & cond;
    other    = mask_q & ~cond;
    pred     = mask_q & cond;
    deferred = ~mask_q & top_q.mask;
    limit_w  = (LimW'(limit_q) < LimW'(STACK_DEPTH)) ? LimW'(limit_q) : LimW'(STACK_DEPTH);
    full     = LimW'(count_q) >= limit_w;
    act      = item_q.tokenless ? (count_q != '0)
                                : (item_q.scalar_rs1 != 32'(count_q));

    mask_d   = mask_q;
    count_d  = count_q;
    set_mask = 1'b0;
    we       = 1'b0;
    waddr    = AddrW'(count_q);
    wdata    = top_q;
    res_d    = '0;
    res_d.status = ST_OK;

    case (item_q.operation)
      OP_TMC: begin
        if (item_q.end_of_packet) begin
          mask_d   = item_q.scalar_rs1[LANES-1:0];
          set_mask = 1'b1;
        end
      end
      OP_SPLIT: begin
        res_d.dst_value = 4'(count_q);
        if (item_q.end_of_packet) begin
          if ((taken != '0) && (other != '0)) begin
            if (full) begin
              res_d.status = ST_FULL;
            end else begin
              mask_d = ($countones(taken) <= $countones(other)) ? taken : other;
              we     = 1'b1;
              waddr  = AddrW'(count_q);
              wdata.mask        = mask_q;
              wdata.else_pc     = item_q.pc + PC_STEP;
              wdata.fallthrough = 1'b0;
              count_d = count_q + 1'b1;
              res_d.divergence = 1'b1;
              set_mask = 1'b1;
            end
          end else begin
            set_mask = 1'b1;
          end
        end
      end
      OP_JOIN: begin
        if (item_q.end_of_packet) begin
          if (act && (count_q == '0)) begin
            res_d.status = ST_EMPTY;
          end else begin
            set_mask = 1'b1;
            if (act) begin
              if (top_q.fallthrough || (item_q.tokenless && (deferred == '0))) begin
                mask_d  = top_q.mask;
                count_d = count_q - 1'b1;
              end else begin
                mask_d            = deferred;
                res_d.redirect    = 1'b1;
                res_d.redirect_pc = top_q.else_pc;
                we                = 1'b1;
                waddr             = AddrW'(count_q - 1'b1);
                wdata.fallthrough = 1'b1;
              end
            end
          end
        end
      end
      OP_PRED: begin
        if (item_q.end_of_packet) begin
          mask_d   = (pred != '0) ? pred : item_q.restore_mask;
          set_mask = 1'b1;
        end
      end
      default: ;
    endcase

    res_d.next_mask   = mask_d;
    res_d.warp_resume = set_mask ? (mask_d != '0) : item_q.release_default;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '1;
      count_q <= '0;
      limit_q <= LIMIT_RESET;
    end else begin
      if (cmd_i.cfg_write) limit_q <= cfg_data_i;
      if (cmd_i.execute) begin
        mask_q  <= mask_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_i;
      top_q  <= mem_q[AddrW'(count_q - 1'b1)];
    end
    if (cmd_i.execute) begin
      res_q <= res_d;
      if (we) mem_q[waddr] <= wdata;
    end
  end

  assign result_o = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= STACK_DEPTH)
    else $error("stack count beyond depth");
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.execute |=> $stable(count_q) && $stable(mask_q))
    else $error("state changed outside execute");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.execute |=> (count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1)
                      || (count_q == $past(count_q) - 1'b1))
    else $error("stack count moved by more than one");

endmodule

// ----- src/warp_divergence_stack_control_core.sv -----
// Top level of the warp divergence stack control block.
// Instantiates wdsc_ctrl and wdsc_dp; depends on wdsc_pkg.
//
// Usage:
//   Input channel: an item transfers at a rising edge with start high and busy low.
//   Each item passes through the execute state after its transfer, then its result shows on
//   result_o for exactly one cycle, marked by result_valid_o. The receiver cannot
//   stall; a result must be taken in the cycle it is shown.
//   The result strobe comes from the registered done flag that follows the execute state.
//   Busy is high during the execute state, so no new item transfers until the current one
//   has executed. A new item may transfer while a result is shown.
//   Configuration: cfg_data_i writes stack_limit when cfg_valid_i and cfg_ready_o are
//   both high; ready is high while no item executes.
//   Reset: thread mask all lanes active, stack empty, stack_limit 8, no result shown.
//   Stack entries are undefined until pushed; no clearing pass.
module warp_divergence_stack_control_core import wdsc_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  wdsc_in_t   in_i,
  output logic       result_valid_o,
  output wdsc_out_t  result_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_data_i
);

  wdsc_cmd_t cmd;

  wdsc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .result_valid_o (result_valid_o),
    .cmd_o          (cmd)
  );

  wdsc_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .result_o   (result_o)
  );

endmodule

// ----- dv/tb_warp_divergence_stack_control_core.sv -----
// Testbench for warp_divergence_stack_control_core: mask-control instructions and
// reconvergence stack behavior, checked against a cycle-free predictor in a scoreboard.
// Depends on wdsc_pkg and the core RTL.
module tb_warp_divergence_stack_control_core import wdsc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = STACK_DEPTH_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 400;
  localparam int unsigned PHASE_ITEMS = 150;

  class mask_stack_scoreboard;
    logic [LANES-1:0] mask_q;
    int unsigned      depth_q;
    logic [3:0]       limit_q;
    logic [LANES-1:0] saved_mask [DEPTH];
    logic [31:0]      saved_pc [DEPTH];
    logic             saved_ft [DEPTH];
    wdsc_out_t        expected_outcomes[$];
    int unsigned      mismatches;

    function new();
      mask_q = '1;
      depth_q = 0;
      limit_q = LIMIT_RESET;
      mismatches = 0;
    endfunction

    function void set_limit(logic [3:0] v);
      limit_q = v;
    endfunction

    function int unsigned depth();
      return depth_q;
    endfunction

    function int unsigned outstanding();
      return expected_outcomes.size();
    endfunction

    function wdsc_out_t resolve_control(wdsc_in_t it);
      wdsc_out_t        r;
      logic [LANES-1:0] cond;
      logic [LANES-1:0] taken;
      logic [LANES-1:0] other;
      logic [LANES-1:0] deferred;
      logic [LANES-1:0] nxt;
      logic             rel;
      logic             set_mask;
      logic             act;
      int unsigned      lim;
      int unsigned      top;
      r = '0;
      nxt = mask_q;
      rel = it.release_default;
      set_mask = 1'b0;
      lim = (limit_q < DEPTH) ? limit_q : DEPTH;
      cond = it.cond_negate ? ~it.lane_cond : it.lane_cond;
      case (it.operation)
        OP_TMC: begin
          if (it.end_of_packet) begin
            nxt = it.scalar_rs1[LANES-1:0];
            set_mask = 1'b1;
          end
        end
        OP_SPLIT: begin
          taken = mask_q & cond;
          other = mask_q & ~cond;
          r.dst_value = depth_q[3:0];
          if (it.end_of_packet) begin
            if (taken != '0 && other != '0) begin
              if (depth_q >= lim) begin
                r.status = ST_FULL;
              end else begin
                nxt = ($countones(taken) <= $countones(other)) ? taken : other;
                saved_mask[depth_q] = mask_q;
                saved_pc[depth_q] = it.pc + PC_STEP;
                saved_ft[depth_q] = 1'b0;
                depth_q++;
                r.divergence = 1'b1;
                set_mask = 1'b1;
              end
            end else begin
              set_mask = 1'b1;
            end
          end
        end
        OP_JOIN: begin
          act = it.tokenless ? (depth_q != 0) : (it.scalar_rs1 != 32'(depth_q));
          if (it.end_of_packet) begin
            if (act && depth_q == 0) begin
              r.status = ST_EMPTY;
            end else begin
              if (act) begin
                top = depth_q - 1;
                if (saved_ft[top]) begin
                  nxt = saved_mask[top];
                  depth_q--;
                end else begin
                  deferred = ~mask_q & saved_mask[top];
                  if (it.tokenless && deferred == '0) begin
                    nxt = saved_mask[top];
                    depth_q--;
                  end else begin
                    nxt = deferred;
                    r.redirect = 1'b1;
                    r.redirect_pc = saved_pc[top];
                    saved_ft[top] = 1'b1;
                  end
                end
              end
              set_mask = 1'b1;
            end
          end
        end
        default: begin
          taken = mask_q & cond;
          if (it.end_of_packet) begin
            nxt = (taken != '0) ? taken : it.restore_mask;
            set_mask = 1'b1;
          end
        end
      endcase
      if (set_mask) begin
        mask_q = nxt;
        rel = (nxt != '0);
      end
      r.next_mask = nxt;
      r.warp_resume = rel;
      return r;
    endfunction

    function void note_item(wdsc_in_t it);
      expected_outcomes.push_back(resolve_control(it));
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_result(wdsc_out_t got);
      wdsc_out_t exp_r;
      if (expected_outcomes.size() == 0) begin
        $error("result strobe with no instruction pending");
        mismatches++;
        return;
      end
      exp_r = expected_outcomes.pop_front();
      compare_field("next_mask", 32'(exp_r.next_mask), 32'(got.next_mask));
      compare_field("warp_resume", 32'(exp_r.warp_resume), 32'(got.warp_resume));
      compare_field("dst_value", 32'(exp_r.dst_value), 32'(got.dst_value));
      compare_field("redirect", 32'(exp_r.redirect), 32'(got.redirect));
      compare_field("redirect_pc", exp_r.redirect_pc, got.redirect_pc);
      compare_field("divergence", 32'(exp_r.divergence), 32'(got.divergence));
      compare_field("status", 32'(exp_r.status), 32'(got.status));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  wdsc_in_t    in_i = '0;
  logic        result_valid_o;
  wdsc_out_t   result_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i = '0;
  int unsigned idle_cycles = 0;

  mask_stack_scoreboard sb = new();

  warp_divergence_stack_control_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_result(result_o);
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[warp_divergence_stack_control_core] ERROR");
      $finish;
    end
  end

  function automatic wdsc_in_t make_instr(op_e op, logic [31:0] pc, logic [3:0] cond,
                                          logic neg, logic tok, logic [31:0] rs1,
                                          logic [3:0] restore, logic eop, logic stall);
    wdsc_in_t it;
    it.operation = op;
    it.pc = pc;
    it.lane_cond = cond;
    it.cond_negate = neg;
    it.tokenless = tok;
    it.scalar_rs1 = rs1;
    it.restore_mask = restore;
    it.end_of_packet = eop;
    it.release_default = stall;
    return it;
  endfunction

  // Mostly well-formed split/join nesting; tokens follow the current stack depth.
  function automatic wdsc_in_t random_instr(int unsigned join_pct);
    wdsc_in_t    it;
    logic [95:0] raw;
    int unsigned pick;
    int unsigned d;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(wdsc_in_t)-1:0];
    it.end_of_packet = ($urandom_range(0, 9) != 0);
    pick = $urandom_range(0, 99);
    d = sb.depth();
    if (pick < 40) begin
      it.operation = OP_SPLIT;
    end else if (pick < 40 + join_pct) begin
      it.operation = OP_JOIN;
      it.tokenless = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 70 && d > 0) begin
        it.scalar_rs1 = 32'(d - 1);
      end else if (pick < 85) begin
        it.scalar_rs1 = 32'(d);
      end
    end else if (pick < 70 + join_pct / 2) begin
      it.operation = OP_TMC;
      if ($urandom_range(0, 1) == 0) begin
        it.scalar_rs1[LANES-1:0] = '1;
      end
    end else begin
      it.operation = OP_PRED;
    end
    return it;
  endfunction

  task automatic issue_instr(input wdsc_in_t it, input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (busy);
    sb.note_item(it);
  endtask

  task automatic drain_outcomes();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  task automatic write_stack_limit(input logic [3:0] v);
    drain_outcomes();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_limit(v);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    wdsc_in_t    directed[$];
    logic [3:0]  limits[6];
    int unsigned join_mix[6];
    logic        burst;
    int unsigned gap;

    limits = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd2, 4'($urandom_range(0, 15))};
    join_mix = '{35, 35, 15, 15, 35, 25};
    burst = 1'b0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed.push_back(make_instr(OP_TMC, 32'h0, 4'h0, 0, 0, 32'hFFFF_FFFF, 4'h0, 1, 0));
    directed.push_back(make_instr(OP_JOIN, 32'h10, 4'h0, 0, 1, 32'h0, 4'h0, 1, 1));
    directed.push_back(make_instr(OP_JOIN, 32'h14, 4'h0, 0, 0, 32'h5, 4'h0, 1, 0));
    directed.push_back(make_instr(OP_JOIN, 32'h18, 4'h0, 0, 0, 32'h0, 4'h0, 1, 1));
    directed.push_back(make_instr(OP_SPLIT, 32'h1C, 4'h5, 0, 0, 32'h0, 4'h0, 0, 1));
    directed.push_back(make_instr(OP_SPLIT, 32'hFFFF_FFFC, 4'h1, 0, 0, 32'h0, 4'h0, 1, 0));
    directed.push_back(make_instr(OP_JOIN, 32'h20, 4'h0, 0, 0, 32'h0, 4'h0, 1, 0));
    directed.push_back(make_instr(OP_JOIN, 32'h24, 4'h0, 0, 0, 32'h0, 4'h0, 1, 0));
    directed.push_back(make_instr(OP_SPLIT, 32'hFFFF_FFFF, 4'h3, 1, 0, 32'h0, 4'h0, 1, 0));
    directed.push_back(make_instr(OP_JOIN, 32'h28, 4'h0, 0, 1, 32'h0, 4'h0, 1, 0));
    directed.push_back(make_instr(OP_JOIN, 32'h2C, 4'h0, 0, 1, 32'h0, 4'h0, 1, 0));
    directed.push_back(make_instr(OP_SPLIT, 32'h30, 4'hF, 0, 0, 32'h0, 4'h0, 1, 0));
    directed.push_back(make_instr(OP_TMC, 32'h34, 4'h0, 0, 0, 32'hFFFF_FFF0, 4'h0, 1, 1));
    directed.push_back(make_instr(OP_SPLIT, 32'h38, 4'h5, 0, 0, 32'h0, 4'h0, 1, 1));
    directed.push_back(make_instr(OP_PRED, 32'h3C, 4'h0, 0, 0, 32'h0, 4'hA, 1, 0));
    directed.push_back(make_instr(OP_PRED, 32'h40, 4'h2, 0, 0, 32'h0, 4'hF, 1, 0));
    directed.push_back(make_instr(OP_TMC, 32'h44, 4'h0, 0, 0, 32'hF, 4'h0, 1, 0));
    directed.push_back(make_instr(OP_SPLIT, 32'h48, 4'h1, 0, 0, 32'h0, 4'h0, 1, 0));
    directed.push_back(make_instr(OP_TMC, 32'h4C, 4'h0, 0, 0, 32'hF, 4'h0, 1, 0));
    directed.push_back(make_instr(OP_JOIN, 32'h50, 4'h0, 0, 1, 32'h0, 4'h0, 1, 0));
    directed.push_back(make_instr(OP_SPLIT, 32'h54, 4'hE, 1, 0, 32'h0, 4'h0, 1, 0));
    directed.push_back(make_instr(OP_TMC, 32'h58, 4'h0, 0, 0, 32'hF, 4'h0, 1, 0));
    directed.push_back(make_instr(OP_JOIN, 32'h5C, 4'h0, 0, 0, 32'h0, 4'h0, 1, 0));
    directed.push_back(make_instr(OP_JOIN, 32'h60, 4'h0, 0, 0, 32'h0, 4'h0, 1, 0));
    directed.push_back(make_instr(OP_PRED, 32'h64, 4'hF, 1, 0, 32'h0, 4'h5, 0, 0));
    directed.push_back(make_instr(OP_TMC, 32'h68, 4'h0, 0, 0, 32'h0, 4'h0, 0, 1));

    foreach (directed[i]) begin
      issue_instr(directed[i], $urandom_range(0, 16));
    end

    foreach (limits[p]) begin
      write_stack_limit(limits[p]);
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 39) == 0) begin
          drain_outcomes();
        end
        if ($urandom_range(0, 19) == 0) begin
          burst = !burst;
        end
        gap = burst ? 0 : $urandom_range(0, 16);
        issue_instr(random_instr(join_mix[p]), gap);
      end
    end

    drain_outcomes();
    repeat (4) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("[warp_divergence_stack_control_core] OK");
    end else begin
      $display("[warp_divergence_stack_control_core] ERROR");
    end
    $finish;
  end

endmodule
